// ----- rtl/iqes_pkg.sv -----
package iqes_pkg;

    typedef enum logic [1:0] {
        CASE_QUAD   = 2'd0,
        CASE_LINEAR = 2'd1,
        CASE_PASS   = 2'd2,
        CASE_NOROOT = 2'd3
    } solve_case_t;

    // Register indexes
    localparam logic [1:0] REG_A    = 2'd0;
    localparam logic [1:0] REG_B    = 2'd1;
    localparam logic [1:0] REG_C    = 2'd2;
    localparam logic [1:0] REG_BAND = 2'd3;

    localparam int DW       = 68;  // discriminant width
    localparam int RW       = 35;  // root width
    localparam int QW       = 64;  // quotient bits formed
    localparam int NUMW     = 64;  // numerator width
    localparam int DENW     = 36;  // denominator width

    localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;

    // Item context carried along the chain of cells
    typedef struct packed {
        logic        quad;       // quadratic case
        logic        b_zero;
        logic        no_root;
        logic        kill;       // result forced to zero unless pass
        logic        pass;
        logic [31:0] y;
        logic [32:0] dmag;       // |y - a|
        logic [31:0] bmag;
    } iqes_ctx_t;

endpackage

// ----- rtl/iqes_sqrt_cell.sv -----
// One restoring square root step: decides one root bit per cycle while enabled.
module iqes_sqrt_cell #(
    parameter int BIT = 34
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  logic                    en,
    input  iqes_pkg::iqes_ctx_t     ctx_in,
    input  logic [iqes_pkg::DW-1:0] rem_in,
    input  logic [iqes_pkg::RW-1:0] root_in,
    output logic                    valid_out,
    output iqes_pkg::iqes_ctx_t     ctx_out,
    output logic [iqes_pkg::DW-1:0] rem_out,
    output logic [iqes_pkg::RW-1:0] root_out
);
    import iqes_pkg::*;

    logic [DW+1:0] trial;
    logic [DW+1:0] rem_ext;
    logic          fits;
    logic          valid_reg;
    iqes_ctx_t     ctx_reg;
    logic [DW-1:0] rem_reg;
    logic [RW-1:0] root_reg;

    // trial = (2*root + 2^BIT) * 2^BIT, root bits above BIT only
    always_comb
    begin
        trial   = ({{(DW+2-RW){1'b0}}, root_in} << (BIT + 1))
                | ({{(DW+1){1'b0}}, 1'b1} << (2 * BIT));
        rem_ext = {2'b00, rem_in};
        fits    = (rem_ext >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg  <= ctx_in;
            rem_reg  <= fits ? DW'(rem_ext - trial) : rem_in;
            root_reg <= fits ? (root_in | (RW'(1) << BIT)) : root_in;
        end
    end

    assign valid_out = valid_reg;
    assign ctx_out   = ctx_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
endmodule

// ----- rtl/iqes_div_cell.sv -----
// One restoring division step: one quotient bit per cycle while enabled.
module iqes_div_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    input  logic                      en,
    input  iqes_pkg::iqes_ctx_t       ctx_in,
    input  logic [iqes_pkg::NUMW-1:0] num_in,
    input  logic [iqes_pkg::DENW-1:0] den_in,
    input  logic [iqes_pkg::DENW:0]   rem_in,
    output logic                      valid_out,
    output iqes_pkg::iqes_ctx_t       ctx_out,
    output logic [iqes_pkg::NUMW-1:0] num_out,
    output logic [iqes_pkg::DENW-1:0] den_out,
    output logic [iqes_pkg::DENW:0]   rem_out
);
    import iqes_pkg::*;

    logic [DENW+1:0] shifted;
    logic [DENW+1:0] diff;
    logic            ge;
    logic            valid_reg;
    iqes_ctx_t       ctx_reg;
    logic [NUMW-1:0] num_reg;
    logic [DENW-1:0] den_reg;
    logic [DENW:0]   rem_reg;

    // shift in next numerator bit; quotient bit enters numerator LSB
    always_comb
    begin
        shifted = {rem_in, num_in[NUMW-1]};
        diff    = shifted - {2'b00, den_in};
        ge      = (shifted >= {2'b00, den_in});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= ctx_in;
            den_reg <= den_in;
            num_reg <= {num_in[NUMW-2:0], ge};
            rem_reg <= ge ? diff[DENW:0] : shifted[DENW:0];
        end
    end

    assign valid_out = valid_reg;
    assign ctx_out   = ctx_reg;
    assign num_out   = num_reg;
    assign den_out   = den_reg;
    assign rem_out   = rem_reg;
endmodule

// ----- rtl/inverse_quadratic_energy_scale_core.sv -----
// Channel | Direction | Ports
// input   | in        | in_valid, in_ready, energy_in
// result  | out       | out_valid, out_ready, energy_out, solve_case
// config  | APB       | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Pipeline: 3 + 35 + 64 + 1 register stages (front products, 35 root cells,
// 64 divide cells, result register). One item per cycle sustained while
// no result is stalled.
// The whole chain advances together; a stalled result holds every stage.
// Reset clears all valid bits and loads the calibration reset values.
module inverse_quadratic_energy_scale_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] energy_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] energy_out,
    output logic [1:0]  solve_case
);
    import iqes_pkg::*;

    localparam int NSQ = RW;
    localparam int NDV = QW;

    logic signed [31:0] a_reg, b_reg, c_reg;
    logic [15:0]        band_reg;
    logic               en;

    // Config registers
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= 32'sd65536;
            c_reg    <= '0;
            band_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_A:    a_reg    <= pwdata;
                REG_B:    b_reg    <= pwdata;
                REG_C:    c_reg    <= pwdata;
                REG_BAND: band_reg <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_A:    prdata = a_reg;
            REG_B:    prdata = b_reg;
            REG_C:    prdata = c_reg;
            REG_BAND: prdata = {16'h0, band_reg};
            default:  prdata = '0;
        endcase
    end

    // Whole chain moves when the output slot is free
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Stage 1: difference and magnitudes
    logic               s1_v_reg;
    logic [31:0]        s1_y_reg;
    logic signed [32:0] s1_diff_reg;
    logic [31:0]        s1_cmag_reg, s1_bmag_reg;
    logic               s1_cneg_reg, s1_bneg_reg, s1_quad_reg, s1_bz_reg;
    logic signed [32:0] diff_c;
    logic [31:0]        cmag_c;

    always_comb
    begin
        diff_c = $signed({energy_in[31], energy_in}) - $signed({a_reg[31], a_reg});
        cmag_c = c_reg[31] ? 32'(-c_reg) : c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_y_reg    <= energy_in;
            s1_diff_reg <= diff_c;
            s1_cmag_reg <= cmag_c;
            s1_bmag_reg <= b_reg[31] ? 32'(-b_reg) : b_reg;
            s1_cneg_reg <= c_reg[31];
            s1_bneg_reg <= b_reg[31];
            s1_quad_reg <= cmag_c > {16'h0, band_reg};
            s1_bz_reg   <= (b_reg == 0);
        end
    end

    // Stage 2: products |c|*|diff| and b*b
    logic        s2_v_reg;
    iqes_ctx_t   s2_ctx_reg;
    logic [64:0] s2_pm_reg;
    logic [63:0] s2_b2_reg;
    logic        s2_ppos_reg;
    logic [32:0] dmag_c;

    assign dmag_c = s1_diff_reg[32] ? 33'(-s1_diff_reg) : s1_diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pm_reg  <= {33'h0, s1_cmag_reg} * {32'h0, dmag_c};
            s2_b2_reg  <= {32'h0, s1_bmag_reg} * {32'h0, s1_bmag_reg};
            s2_ppos_reg <= (dmag_c != 0) && (s1_cneg_reg == !s1_diff_reg[32]);
            s2_ctx_reg.quad    <= s1_quad_reg;
            s2_ctx_reg.b_zero  <= s1_bz_reg;
            s2_ctx_reg.no_root <= 1'b0;
            s2_ctx_reg.kill    <= (s1_diff_reg[32] != s1_bneg_reg) || (dmag_c == 0)
                                  || s1_bz_reg;
            s2_ctx_reg.pass    <= !s1_quad_reg && s1_bz_reg;
            s2_ctx_reg.y       <= s1_y_reg;
            s2_ctx_reg.dmag    <= dmag_c;
            s2_ctx_reg.bmag    <= s1_bmag_reg;
        end
    end

    // Stage 3: discriminant
    logic          s3_v_reg;
    iqes_ctx_t     s3_ctx_reg;
    iqes_ctx_t     s3_ctx_next;
    logic [DW-1:0] s3_d_reg;
    logic [DW-1:0] f4, b2x;

    always_comb
    begin
        f4  = {1'b0, s2_pm_reg, 2'b00};
        b2x = {4'h0, s2_b2_reg};
        s3_ctx_next         = s2_ctx_reg;
        s3_ctx_next.no_root = s2_ppos_reg && s2_ctx_reg.quad && (f4 > b2x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ctx_reg <= s3_ctx_next;
            s3_d_reg   <= s2_ppos_reg ? (b2x - f4) : (b2x + f4);
        end
    end

    // Square root chain
    logic                v_sq   [0:NSQ];
    iqes_ctx_t           ctx_sq [0:NSQ];
    logic [DW-1:0]       rem_sq [0:NSQ];
    logic [RW-1:0]       root_sq[0:NSQ];

    assign v_sq[0]    = s3_v_reg;
    assign ctx_sq[0]  = s3_ctx_reg;
    assign rem_sq[0]  = s3_d_reg;
    assign root_sq[0] = '0;

    for (genvar g = 0; g < NSQ; g++)
    begin : g_sqrt
        iqes_sqrt_cell #(.BIT(NSQ - 1 - g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_in (v_sq[g]),
            .en       (en),
            .ctx_in   (ctx_sq[g]),
            .rem_in   (rem_sq[g]),
            .root_in  (root_sq[g]),
            .valid_out(v_sq[g+1]),
            .ctx_out  (ctx_sq[g+1]),
            .rem_out  (rem_sq[g+1]),
            .root_out (root_sq[g+1])
        );
    end

    // Divider operands
    logic                v_dv   [0:NDV];
    iqes_ctx_t           ctx_dv [0:NDV];
    logic [NUMW-1:0]     num_dv [0:NDV];
    logic [DENW-1:0]     den_dv [0:NDV];
    logic [DENW:0]       rem_dv [0:NDV];
    iqes_ctx_t           cq;

    assign cq        = ctx_sq[NSQ];
    assign v_dv[0]   = v_sq[NSQ];
    assign ctx_dv[0] = cq;
    assign num_dv[0] = cq.quad ? (NUMW'(cq.dmag) << (FRAC_BITS + 1))
                               : (NUMW'(cq.dmag) << FRAC_BITS);
    assign den_dv[0] = cq.quad ? (DENW'(cq.bmag) + DENW'(root_sq[NSQ]))
                               : DENW'(cq.bmag);
    assign rem_dv[0] = '0;

    for (genvar g = 0; g < NDV; g++)
    begin : g_div
        iqes_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_in (v_dv[g]),
            .en       (en),
            .ctx_in   (ctx_dv[g]),
            .num_in   (num_dv[g]),
            .den_in   (den_dv[g]),
            .rem_in   (rem_dv[g]),
            .valid_out(v_dv[g+1]),
            .ctx_out  (ctx_dv[g+1]),
            .num_out  (num_dv[g+1]),
            .den_out  (den_dv[g+1]),
            .rem_out  (rem_dv[g+1])
        );
    end

    // Result select and saturation
    iqes_ctx_t   cf;
    logic [30:0] res_c;
    solve_case_t kase_c;
    logic [63:0] q;

    always_comb
    begin
        cf = ctx_dv[NDV];
        q  = num_dv[NDV];
        if (cf.quad)
            kase_c = cf.no_root ? CASE_NOROOT : CASE_QUAD;
        else if (cf.pass)
            kase_c = CASE_PASS;
        else
            kase_c = CASE_LINEAR;
        if (cf.pass)
            res_c = cf.y[31] ? '0 : cf.y[30:0];
        else if ((cf.quad && cf.no_root) || cf.kill)
            res_c = '0;
        else if (q[63:31] != 0)
            res_c = OUT_MAX;
        else
            res_c = q[30:0];
    end

    logic        out_v_reg;
    logic [30:0] out_e_reg;
    logic [1:0]  out_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= v_dv[NDV];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_e_reg <= res_c;
            out_k_reg <= kase_c;
        end
    end

    assign out_valid  = out_v_reg;
    assign energy_out = out_e_reg;
    assign solve_case = out_k_reg;
endmodule

// ----- rtl/iqes_checker.sv -----
module iqes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [30:0] energy_out,
    input logic [1:0]  solve_case,
    input logic        pready
);
    import iqes_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(energy_out))
        else $error("result changed while stalled");

    // No root always reports zero energy
    a_noroot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && solve_case == CASE_NOROOT |-> energy_out == 0)
        else $error("no-root result nonzero");

    // Input ready follows output backpressure
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready mismatch");

    // Offered input item waits until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input item withdrawn");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind inverse_quadratic_energy_scale_core iqes_checker u_iqes_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .energy_out(energy_out),
    .solve_case(solve_case), .pready(pready)
);
